// ===== rtl/core/htd_pkg.sv =====
`default_nettype none

package htd_pkg;

    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int NODE_COUNT_DEF    = 512;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_SYMBOL  = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_OVERLAP = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  symbol_in;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] symbol_out;
        logic [2:0] status;
        logic       last;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/core/htd_node_ram.sv =====
`default_nettype none

module htd_node_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 27
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/huffman_tree_decoder.sv =====
`default_nettype none

// Huffman code tree decoder. Items are taken on start while busy is low.
// Clear gives no result; the node table is not swept, a fill count marks
// which nodes exist. A load walks its code through a node RAM with separate
// read and write ports and registered read, and gives one result. A decode
// walks the byte one bit at a time; a bit that descends to a node reads
// that node from the RAM before it is checked. Each decode result is held
// back until the next one is known so that last can be set; the final one
// comes out as the item ends. Results appear for one cycle with o_strobe
// and cannot be stalled by the receiver.
module huffman_tree_decoder #(
    parameter int MAX_CODE_BITS = htd_pkg::MAX_CODE_BITS_DEF,
    parameter int NODE_COUNT    = htd_pkg::NODE_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire htd_pkg::t_in  i_item,
    output logic               o_strobe,
    output htd_pkg::t_out      o_result
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int UW = $clog2(NODE_COUNT + 1);
    localparam int NW = 2 * AW + 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_EVAL,
        S_DC_RD,
        S_DC_EVAL,
        S_DC_CHK,
        S_DC_END
    } t_state;

    t_state          r_state, n_state;
    logic [NW-1:0]   r_root, n_root;
    logic [UW-1:0]   r_used, n_used;
    logic [AW-1:0]   r_walk, n_walk;
    logic [AW-1:0]   r_n, n_n;
    logic            r_fresh, n_fresh;
    logic [6:0]      r_left, n_left;
    logic            r_ovl, n_ovl;
    logic [31:0]     r_code, n_code;
    logic [7:0]      r_sym, n_sym;
    logic [7:0]      r_byte, n_byte;
    logic [2:0]      r_cnt, n_cnt;
    logic            r_pend_v, n_pend_v;
    htd_pkg::t_out   r_pend, n_pend;
    logic            r_strobe, n_strobe;
    htd_pkg::t_out   r_out, n_out;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [NW-1:0]   ram_wdata, ram_rdata;

    logic [6:0]      len_eff;
    logic [NW-1:0]   cur_node;
    logic [AW-1:0]   cur_c0, cur_c1, cur_child;
    logic [7:0]      cur_sym;
    logic            cur_has;
    logic [6:0]      ld_pos;
    logic            ld_bit;
    logic            dc_bit;
    logic [AW-1:0]   new_c;
    logic [NW-1:0]   upd_node;
    logic            emit;
    htd_pkg::t_out   emit_val;

    htd_node_ram #(
        .DEPTH (NODE_COUNT),
        .AW    (AW),
        .DW    (NW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign len_eff = ({1'b0, i_item.code_length} > 7'(MAX_CODE_BITS))
                   ? 7'(MAX_CODE_BITS) : {1'b0, i_item.code_length};

    always_comb begin
        if (r_state == S_LD_EVAL) begin
            cur_node = (r_n == '0) ? r_root : (r_fresh ? '0 : ram_rdata);
        end else if (r_state == S_DC_CHK) begin
            cur_node = ram_rdata;
        end else begin
            cur_node = (r_walk == '0) ? r_root : ram_rdata;
        end
    end

    assign cur_c0  = cur_node[AW-1:0];
    assign cur_c1  = cur_node[2*AW-1:AW];
    assign cur_sym = cur_node[2*AW+7:2*AW];
    assign cur_has = cur_node[NW-1];

    assign ld_pos    = r_left - 7'd1;
    assign ld_bit    = (ld_pos[6:5] == 2'b00) ? r_code[ld_pos[4:0]] : 1'b0;
    assign dc_bit    = r_byte[7];
    assign cur_child = ((r_state == S_LD_EVAL) ? ld_bit : dc_bit) ? cur_c1 : cur_c0;
    assign new_c     = r_used[AW-1:0];
    assign upd_node  = ld_bit ? {cur_has, cur_sym, new_c, cur_c0}
                              : {cur_has, cur_sym, cur_c1, new_c};

    always_comb begin
        n_state   = r_state;
        n_root    = r_root;
        n_used    = r_used;
        n_walk    = r_walk;
        n_n       = r_n;
        n_fresh   = r_fresh;
        n_left    = r_left;
        n_ovl     = r_ovl;
        n_code    = r_code;
        n_sym     = r_sym;
        n_byte    = r_byte;
        n_cnt     = r_cnt;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_strobe  = 1'b0;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_n;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_walk;
        emit      = 1'b0;
        emit_val  = '{symbol_out: 8'd0, status: htd_pkg::ST_BAD, last: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.opcode)
                        htd_pkg::OP_LOAD: begin
                            if (len_eff == 7'd0) begin
                                n_strobe = 1'b1;
                                n_out = '{symbol_out: 8'd0, status: htd_pkg::ST_OVERLAP,
                                          last: 1'b1};
                            end else begin
                                n_n     = '0;
                                n_fresh = 1'b0;
                                n_left  = len_eff;
                                n_ovl   = 1'b0;
                                n_code  = i_item.code_bits;
                                n_sym   = i_item.symbol_in;
                                n_state = S_LD_RD;
                            end
                        end
                        htd_pkg::OP_DECODE: begin
                            n_byte   = i_item.data_byte;
                            n_cnt    = 3'd7;
                            n_pend_v = 1'b0;
                            n_state  = S_DC_RD;
                        end
                        htd_pkg::OP_CLEAR: begin
                            n_root = '0;
                            n_used = UW'(1);
                            n_walk = '0;
                        end
                        default: ;
                    endcase
                end
            end

            S_LD_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_n;
                n_state   = S_LD_EVAL;
            end

            S_LD_EVAL: begin
                if (r_left == 7'd0) begin
                    ram_wdata = {1'b1, r_sym, cur_c1, cur_c0};
                    if (r_n == '0) begin
                        n_root = ram_wdata;
                    end else begin
                        ram_we = 1'b1;
                    end
                    n_strobe = 1'b1;
                    n_out = '{symbol_out: 8'd0,
                              status: (r_ovl || cur_c0 != '0 || cur_c1 != '0)
                                      ? htd_pkg::ST_OVERLAP : htd_pkg::ST_OK,
                              last: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    n_ovl = r_ovl | cur_has;
                    if (cur_child != '0) begin
                        n_n     = cur_child;
                        n_fresh = 1'b0;
                        n_left  = r_left - 7'd1;
                        n_state = S_LD_RD;
                    end else if (r_used == UW'(NODE_COUNT)) begin
                        if (r_fresh && r_n != '0) begin
                            ram_we = 1'b1;
                        end
                        n_strobe = 1'b1;
                        n_out = '{symbol_out: 8'd0, status: htd_pkg::ST_FULL, last: 1'b1};
                        n_state = S_IDLE;
                    end else begin
                        ram_wdata = upd_node;
                        if (r_n == '0) begin
                            n_root = upd_node;
                        end else begin
                            ram_we = 1'b1;
                        end
                        n_used  = r_used + UW'(1);
                        n_n     = new_c;
                        n_fresh = 1'b1;
                        n_left  = r_left - 7'd1;
                        n_state = S_LD_RD;
                    end
                end
            end

            S_DC_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_walk;
                n_state   = S_DC_EVAL;
            end

            S_DC_EVAL: begin
                if (cur_child == '0) begin
                    emit   = 1'b1;
                    n_walk = '0;
                    n_byte = {r_byte[6:0], 1'b0};
                    if (r_cnt == 3'd0) begin
                        n_state = S_DC_END;
                    end else begin
                        n_cnt = r_cnt - 3'd1;
                    end
                end else begin
                    n_walk    = cur_child;
                    ram_re    = 1'b1;
                    ram_raddr = cur_child;
                    n_state   = S_DC_CHK;
                end
            end

            S_DC_CHK: begin
                if (cur_c0 == '0 && cur_c1 == '0) begin
                    emit     = 1'b1;
                    emit_val = cur_has
                        ? '{symbol_out: cur_sym, status: htd_pkg::ST_SYMBOL, last: 1'b0}
                        : '{symbol_out: 8'd0, status: htd_pkg::ST_BAD, last: 1'b0};
                    n_walk = '0;
                end
                n_byte = {r_byte[6:0], 1'b0};
                if (r_cnt == 3'd0) begin
                    n_state = S_DC_END;
                end else begin
                    n_cnt   = r_cnt - 3'd1;
                    n_state = S_DC_EVAL;
                end
            end

            S_DC_END: begin
                if (r_pend_v) begin
                    n_strobe = 1'b1;
                    n_out = '{symbol_out: r_pend.symbol_out, status: r_pend.status,
                              last: 1'b1};
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        // hold each decode result until the next one shows whether it was final
        if (emit) begin
            if (r_pend_v) begin
                n_strobe = 1'b1;
                n_out    = r_pend;
            end
            n_pend   = emit_val;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_root   <= '0;
            r_used   <= UW'(1);
            r_walk   <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_root   <= n_root;
            r_used   <= n_used;
            r_walk   <= n_walk;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
        r_n     <= n_n;
        r_fresh <= n_fresh;
        r_left  <= n_left;
        r_ovl   <= n_ovl;
        r_code  <= n_code;
        r_sym   <= n_sym;
        r_byte  <= n_byte;
        r_cnt   <= n_cnt;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire
